@@ src/rss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants of the restriction site scanner.
// ----------------------------------------------------------------------------
package rss_pkg;

    // Site and read limits
    localparam int MAX_SITE_BASES = 16;
    localparam int MAX_READ_BASES = 1024;

    // Field widths
    localparam int BASE_W      = 3;
    localparam int POS_W       = 11;
    localparam int SITE_LEN_W  = 5;
    localparam int IDX_W       = $clog2(MAX_SITE_BASES);
    localparam int PATTERN_W   = 2 * MAX_SITE_BASES;

    // Configuration port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [BASE_W-1:0] t_base;
    typedef logic [POS_W-1:0]  t_pos;

    // Code that never matches a site base
    localparam t_base BASE_NONE = 3'd4;

    localparam t_pos READ_LIMIT = POS_W'(MAX_READ_BASES);
    localparam t_pos COUNT_MAX  = {POS_W{1'b1}};

    // Result kinds
    localparam logic KIND_CUT     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_SITE_PATTERN = 2'd0,
        REG_SITE_LENGTH  = 2'd1,
        REG_CUT_OFFSET   = 2'd2,
        REG_LONG_MODE    = 2'd3
    } t_reg_idx;

    // Control of the history cell row
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // One result transaction
    typedef struct packed {
        logic kind;
        t_pos position;
        t_pos longest_start;
        t_pos longest_length;
        t_pos cut_count;
        logic overflow;
        logic last;
    } t_result;

endpackage

@@ src/rss_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_cell
// One history cell: holds one base, passes it to its neighbor on a shift and
// compares the incoming base against its site base.
// ----------------------------------------------------------------------------
module rss_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rss_pkg::t_cell_ctrl i_ctrl,
    input  rss_pkg::t_base     i_base,
    input  logic [1:0]         i_want,
    input  logic               i_enable,
    output rss_pkg::t_base     o_base,
    output logic               o_match
);
    import rss_pkg::*;

    t_base r_base;

    // Hold the base, clear it at the end of a read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_NONE;
        end else if (i_ctrl.clear) begin
            r_base <= BASE_NONE;
        end else if (i_ctrl.shift) begin
            r_base <= i_base;
        end
    end

    // Compare the base entering this cell; cells past the site always agree
    assign o_match = !i_enable || (i_base == {1'b0, i_want});
    assign o_base  = r_base;

endmodule

@@ src/rss_cell_row.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_cell_row
// Row of history cells, most recent base in cell 0. Reports a site hit on
// the window that includes the base being shifted in.
// ----------------------------------------------------------------------------
module rss_cell_row (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rss_pkg::t_cell_ctrl            i_ctrl,
    input  rss_pkg::t_base                 i_base,
    input  logic [rss_pkg::PATTERN_W-1:0]  i_pattern,
    input  logic [rss_pkg::SITE_LEN_W-1:0] i_site_len,
    output logic                           o_hit
);
    import rss_pkg::*;

    t_base                     w_q     [MAX_SITE_BASES];
    logic [MAX_SITE_BASES-1:0] w_match;

    for (genvar k = 0; k < MAX_SITE_BASES; k++) begin : g_cell
        t_base          w_in;
        logic [IDX_W-1:0] w_idx;
        logic [1:0]     w_want;
        logic           w_enable;

        // Cell k sees site base (length - 1 - k)
        assign w_idx    = IDX_W'(i_site_len - SITE_LEN_W'(1) - SITE_LEN_W'(k));
        assign w_want   = i_pattern[{w_idx, 1'b0} +: 2];
        assign w_enable = SITE_LEN_W'(k) < i_site_len;

        if (k == 0) begin : g_head
            assign w_in = i_base;
        end else begin : g_link
            assign w_in = w_q[k-1];
        end

        rss_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (i_ctrl),
            .i_base   (w_in),
            .i_want   (w_want),
            .i_enable (w_enable),
            .o_base   (w_q[k]),
            .o_match  (w_match[k])
        );
    end

    assign o_hit = &w_match;

endmodule

@@ src/rss_result_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_result_queue
// Small result queue: takes up to two results a cycle, hands out one while i_ready is high.
// ----------------------------------------------------------------------------
module rss_result_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  rss_pkg::t_result           i_push0,
    input  rss_pkg::t_result           i_push1,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rss_pkg::t_result           o_data,
    output logic [rss_pkg::QCNT_W-1:0] o_count
);
    import rss_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign w_pop = o_valid && i_ready;

    // Store incoming results in order
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[QPTR_W'(r_wr_ptr + 1'b1)] <= i_push1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= QPTR_W'(r_wr_ptr + QPTR_W'(i_push_cnt));
            r_rd_ptr <= QPTR_W'(r_rd_ptr + QPTR_W'(w_pop));
            r_count  <= QCNT_W'(r_count + QCNT_W'(i_push_cnt) - QCNT_W'(w_pop));
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QCNT_W + 1)'(r_count) + (QCNT_W + 1)'(i_push_cnt) - (QCNT_W + 1)'(w_pop)
            <= (QCNT_W + 1)'(QUEUE_DEPTH))
        else $error("result queue overrun");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |=> (r_rd_ptr == $past(r_rd_ptr)))
        else $error("result queue read while empty");

endmodule

@@ src/restriction_site_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restriction_site_scanner
// Scans a read base by base for non-overlapping copies of a configured site
// and reports cut positions and an end-of-read fragment summary.
// ----------------------------------------------------------------------------
// The block takes one base per clock cycle while o_ready is high. A base
// enters a row of sixteen history cells that compare it against the site in
// the cycle it arrives; in the next cycle the match bookkeeping turns the hit
// into a cut record and, on the last base of a read, a summary. Results pass
// through the front-stage registers to an eight-entry result queue that drives
// o_valid; a base that makes a cut and ends a read produces two transactions
// unless long mode is set, so the output runs at one result per cycle while
// i_ready is high, and input is held off only when the queue has fewer than
// two free entries beyond those claimed by the base in flight.
// ----------------------------------------------------------------------------
module restriction_site_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Base input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  rss_pkg::t_base                 i_base,
    input  logic                           i_read_end,
    // Result output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_kind,
    output rss_pkg::t_pos                  o_position,
    output rss_pkg::t_pos                  o_longest_start,
    output rss_pkg::t_pos                  o_longest_length,
    output rss_pkg::t_pos                  o_cut_count,
    output logic                           o_overflow,
    output logic                           o_last,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rss_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import rss_pkg::*;

    // Configuration registers
    logic [PATTERN_W-1:0]  r_site_pattern;
    logic [SITE_LEN_W-1:0] r_site_length;
    logic [SITE_LEN_W-1:0] r_cut_offset;
    logic                  r_long_mode;

    // Front stage
    t_pos                  r_base_index;
    logic                  r_a_valid;
    logic                  r_a_hit;
    logic                  r_a_end;
    logic                  r_a_ovf;
    t_pos                  r_a_start;
    t_pos                  r_a_cut;
    t_pos                  r_a_pos;

    // Per-read bookkeeping
    t_pos                  r_resume;
    t_pos                  r_prev_cut;
    t_pos                  r_best_start;
    t_pos                  r_best_len;
    t_pos                  r_match_count;
    logic                  r_ovf_seen;

    logic                  w_cfg_wr;
    t_reg_idx              w_reg_idx;
    logic [SITE_LEN_W-1:0] w_len;
    logic [SITE_LEN_W-1:0] w_off;
    logic [SITE_LEN_W-1:0] w_gap;
    logic                  w_in_fire;
    logic                  w_ovf_base;
    t_pos                  w_idx_new;
    logic                  w_row_hit;
    t_cell_ctrl            w_row_ctrl;
    logic [QCNT_W:0]       w_reserved;
    logic [QCNT_W-1:0]     w_q_count;
    t_result               w_q_data;

    logic                  w_take;
    t_pos                  w_len1;
    t_pos                  w_best1_start;
    t_pos                  w_best1_len;
    t_pos                  w_prev1;
    t_pos                  w_count1;
    logic                  w_ovf1;
    t_pos                  w_len2;
    t_pos                  w_best2_start;
    t_pos                  w_best2_len;
    t_result               w_cut_rec;
    t_result               w_sum_rec;
    logic                  w_emit_cut;
    logic                  w_emit_sum;
    logic [1:0]            w_push_cnt;
    t_result               w_push0;
    t_result               w_push1;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_pattern <= '0;
            r_site_length  <= SITE_LEN_W'(4);
            r_cut_offset   <= SITE_LEN_W'(1);
            r_long_mode    <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_SITE_PATTERN: r_site_pattern <= pwdata[PATTERN_W-1:0];
                REG_SITE_LENGTH:  r_site_length  <= pwdata[SITE_LEN_W-1:0];
                REG_CUT_OFFSET:   r_cut_offset   <= pwdata[SITE_LEN_W-1:0];
                REG_LONG_MODE:    r_long_mode    <= pwdata[0];
            endcase
        end
    end

    // Read back raw register values
    always_comb begin
        unique case (w_reg_idx)
            REG_SITE_PATTERN: prdata = APB_DATA_W'(r_site_pattern);
            REG_SITE_LENGTH:  prdata = APB_DATA_W'(r_site_length);
            REG_CUT_OFFSET:   prdata = APB_DATA_W'(r_cut_offset);
            REG_LONG_MODE:    prdata = APB_DATA_W'(r_long_mode);
        endcase
    end

    // Clamp site length and cut offset into range
    always_comb begin
        if (r_site_length == '0) begin
            w_len = SITE_LEN_W'(1);
        end else if (r_site_length > SITE_LEN_W'(MAX_SITE_BASES)) begin
            w_len = SITE_LEN_W'(MAX_SITE_BASES);
        end else begin
            w_len = r_site_length;
        end
        if (r_cut_offset == '0) begin
            w_off = SITE_LEN_W'(1);
        end else if (r_cut_offset > w_len) begin
            w_off = w_len;
        end else begin
            w_off = r_cut_offset;
        end
        w_gap = SITE_LEN_W'(w_len - w_off + SITE_LEN_W'(1));
    end

    // ------------------------------------------------------------------
    // Front stage: history row and hit detection
    // ------------------------------------------------------------------
    assign w_reserved = r_a_valid ? (QCNT_W + 1)'(w_q_count) + (QCNT_W + 1)'(2)
                                  : (QCNT_W + 1)'(w_q_count);
    assign o_ready    = w_reserved <= (QCNT_W + 1)'(QUEUE_DEPTH - 2);
    assign w_in_fire  = i_valid && o_ready;
    assign w_ovf_base = (r_base_index == READ_LIMIT);
    assign w_idx_new  = POS_W'(r_base_index + POS_W'(1));

    assign w_row_ctrl.shift = w_in_fire && !w_ovf_base;
    assign w_row_ctrl.clear = w_in_fire && i_read_end;

    rss_cell_row u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_row_ctrl),
        .i_base     (i_base),
        .i_pattern  (r_site_pattern),
        .i_site_len (w_len),
        .o_hit      (w_row_hit)
    );

    // Register the hit, match start and cut position of each base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_index <= '0;
            r_a_valid    <= 1'b0;
        end else begin
            r_a_valid <= w_in_fire;
            if (w_in_fire) begin
                if (i_read_end) begin
                    r_base_index <= '0;
                end else if (!w_ovf_base) begin
                    r_base_index <= w_idx_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_a_hit   <= !w_ovf_base && w_row_hit && (w_idx_new >= POS_W'(w_len));
            r_a_end   <= i_read_end;
            r_a_ovf   <= w_ovf_base;
            r_a_start <= POS_W'(w_idx_new - POS_W'(w_len));
            r_a_cut   <= POS_W'(w_idx_new - POS_W'(w_gap));
            r_a_pos   <= w_ovf_base ? r_base_index : w_idx_new;
        end
    end

    // ------------------------------------------------------------------
    // Back stage: non-overlap check, fragments, results
    // ------------------------------------------------------------------
    always_comb begin
        w_take = r_a_valid && r_a_hit && (r_a_start >= r_resume);
        w_len1 = POS_W'(r_a_cut - r_prev_cut);

        // Fragment ending at this cut
        if (w_take && (w_len1 > r_best_len)) begin
            w_best1_start = r_prev_cut;
            w_best1_len   = w_len1;
        end else begin
            w_best1_start = r_best_start;
            w_best1_len   = r_best_len;
        end
        w_prev1  = w_take ? r_a_cut : r_prev_cut;
        w_count1 = (w_take && (r_match_count != COUNT_MAX))
                 ? POS_W'(r_match_count + POS_W'(1)) : r_match_count;
        w_ovf1   = r_ovf_seen || r_a_ovf;

        // Fragment ending at the read end
        w_len2 = POS_W'(r_a_pos - w_prev1);
        if (w_len2 > w_best1_len) begin
            w_best2_start = w_prev1;
            w_best2_len   = w_len2;
        end else begin
            w_best2_start = w_best1_start;
            w_best2_len   = w_best1_len;
        end

        w_emit_cut = w_take && !r_long_mode;
        w_emit_sum = r_a_valid && r_a_end;

        w_cut_rec                = '0;
        w_cut_rec.kind           = KIND_CUT;
        w_cut_rec.position       = r_a_cut;
        w_cut_rec.last           = !w_emit_sum;

        w_sum_rec.kind           = KIND_SUMMARY;
        w_sum_rec.position       = r_a_pos;
        w_sum_rec.longest_start  = w_best2_start;
        w_sum_rec.longest_length = w_best2_len;
        w_sum_rec.cut_count      = w_count1;
        w_sum_rec.overflow       = w_ovf1;
        w_sum_rec.last           = 1'b1;

        // Order the results into the queue
        w_push_cnt = 2'(w_emit_cut) + 2'(w_emit_sum);
        w_push0    = w_emit_cut ? w_cut_rec : w_sum_rec;
        w_push1    = w_sum_rec;
    end

    // Update per-read state, drop it after the summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resume      <= '0;
            r_prev_cut    <= '0;
            r_best_start  <= '0;
            r_best_len    <= '0;
            r_match_count <= '0;
            r_ovf_seen    <= 1'b0;
        end else if (r_a_valid) begin
            if (r_a_end) begin
                r_resume      <= '0;
                r_prev_cut    <= '0;
                r_best_start  <= '0;
                r_best_len    <= '0;
                r_match_count <= '0;
                r_ovf_seen    <= 1'b0;
            end else begin
                if (w_take) begin
                    r_resume <= r_a_pos;
                end
                r_prev_cut    <= w_prev1;
                r_best_start  <= w_best1_start;
                r_best_len    <= w_best1_len;
                r_match_count <= w_count1;
                r_ovf_seen    <= w_ovf1;
            end
        end
    end

    rss_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_push0    (w_push0),
        .i_push1    (w_push1),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (w_q_data),
        .o_count    (w_q_count)
    );

    assign o_kind           = w_q_data.kind;
    assign o_position       = w_q_data.position;
    assign o_longest_start  = w_q_data.longest_start;
    assign o_longest_length = w_q_data.longest_length;
    assign o_cut_count      = w_q_data.cut_count;
    assign o_overflow       = w_q_data.overflow;
    assign o_last           = w_q_data.last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_index <= READ_LIMIT)
        else $error("base index beyond read limit");

    a_no_hit_on_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_ovf) |-> !w_take)
        else $error("match taken from an overflow base");

    a_read_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_end) |=> (r_match_count == '0 && r_prev_cut == '0
                                    && r_resume == '0))
        else $error("per-read state not cleared after summary");

    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_read_end) |=> (r_base_index == '0))
        else $error("base index not cleared at read end");

endmodule

@@ test/rss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_checker
// Watches the base, result and configuration channels of the restriction
// site scanner, predicts every result transaction from the accepted bases
// and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module rss_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Base channel
    input  logic                           i_base_valid,
    input  logic                           i_base_ready,
    input  rss_pkg::t_base                 i_base,
    input  logic                           i_read_end,
    // Result channel
    input  logic                           i_result_valid,
    input  logic                           i_result_ready,
    input  rss_pkg::t_result               i_result,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rss_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    // Status for the testbench top
    output int                             o_fault_count,
    output int                             o_records_due
);
    import rss_pkg::*;

    localparam int MAX_PRINTED = 40;

    // Shadow of the configuration registers
    logic [PATTERN_W-1:0]  site_bits;
    logic [SITE_LEN_W-1:0] site_len_reg;
    logic [SITE_LEN_W-1:0] cut_off_reg;
    logic                  long_reg;

    // Per-read scan state
    t_base       history [MAX_SITE_BASES];
    int unsigned held;
    int unsigned resume_at;
    int unsigned prev_cut;
    int unsigned best_start;
    int unsigned best_len;
    int unsigned hit_count;
    logic        overflow_seen;

    t_result     due_records [$];
    int          fault_total = 0;

    task automatic note_fault(input string msg);
        if (fault_total < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        fault_total++;
    endtask

    task automatic match_field(input string name, input logic [POS_W-1:0] got,
                               input logic [POS_W-1:0] want);
        if (got !== want) begin
            note_fault($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic restart_read();
        for (int k = 0; k < MAX_SITE_BASES; k++) history[k] = BASE_NONE;
        held          = 0;
        resume_at     = 0;
        prev_cut      = 0;
        best_start    = 0;
        best_len      = 0;
        hit_count     = 0;
        overflow_seen = 1'b0;
    endtask

    // Keep a fragment only when strictly longer than the best so far
    task automatic keep_longer(input int unsigned start, input int unsigned stop);
        int unsigned span;
        span = stop - start;
        if (span > best_len) begin
            best_start = start;
            best_len   = span;
        end
    endtask

    // Advance the scan by one base and queue the results it causes
    task automatic scan_base(input t_base b, input logic read_end);
        int unsigned span;
        int unsigned off;
        int unsigned first;
        int unsigned cut_at;
        logic        hit;
        logic        cut_made;
        t_result     rec;
        span = site_len_reg;
        if (span < 1) span = 1;
        if (span > MAX_SITE_BASES) span = MAX_SITE_BASES;
        off = cut_off_reg;
        if (off < 1) off = 1;
        if (off > span) off = span;
        cut_made = 1'b0;
        cut_at   = 0;

        if (held >= MAX_READ_BASES) begin
            // drop the base, only flag it
            overflow_seen = 1'b1;
        end else begin
            for (int k = MAX_SITE_BASES - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = b;
            held++;
            hit = (held >= span);
            for (int k = 0; k < span; k++) begin
                if (history[span-1-k] != {1'b0, site_bits[2*k +: 2]}) hit = 1'b0;
            end
            if (hit) begin
                first = held - span;
                if (first >= resume_at) begin
                    cut_at    = first + off - 1;
                    resume_at = held;
                    keep_longer(prev_cut, cut_at);
                    prev_cut  = cut_at;
                    if (hit_count < COUNT_MAX) hit_count++;
                    cut_made  = 1'b1;
                end
            end
        end

        if (cut_made && !long_reg) begin
            rec          = '0;
            rec.kind     = KIND_CUT;
            rec.position = t_pos'(cut_at);
            rec.last     = !read_end;
            due_records  = {due_records, rec};
        end
        if (read_end) begin
            keep_longer(prev_cut, held);
            rec                = '0;
            rec.kind           = KIND_SUMMARY;
            rec.position       = t_pos'(held);
            rec.longest_start  = t_pos'(best_start);
            rec.longest_length = t_pos'(best_len);
            rec.cut_count      = t_pos'(hit_count);
            rec.overflow       = overflow_seen;
            rec.last           = 1'b1;
            due_records        = {due_records, rec};
            restart_read();
        end
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_record(input t_result got);
        t_result want;
        if (due_records.size() == 0) begin
            note_fault($sformatf("result with nothing expected, kind %0d position %0d",
                                 got.kind, got.position));
        end else begin
            want = due_records.pop_front();
            match_field("kind", got.kind, want.kind);
            match_field("position", got.position, want.position);
            match_field("longest_start", got.longest_start, want.longest_start);
            match_field("longest_length", got.longest_length, want.longest_length);
            match_field("cut_count", got.cut_count, want.cut_count);
            match_field("overflow", got.overflow, want.overflow);
            match_field("last", got.last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            site_bits    = '0;
            site_len_reg = 5'd4;
            cut_off_reg  = 5'd1;
            long_reg     = 1'b0;
            restart_read();
            due_records.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_ADDR_W-1:2]))
                    REG_SITE_PATTERN: site_bits    = pwdata[PATTERN_W-1:0];
                    REG_SITE_LENGTH:  site_len_reg = pwdata[SITE_LEN_W-1:0];
                    REG_CUT_OFFSET:   cut_off_reg  = pwdata[SITE_LEN_W-1:0];
                    REG_LONG_MODE:    long_reg     = pwdata[0];
                    default: ;
                endcase
            end
            if (i_result_valid && i_result_ready) check_record(i_result);
            if (i_base_valid && i_base_ready) scan_base(i_base, i_read_end);
        end
        o_records_due <= due_records.size();
        o_fault_count <= fault_total;
    end

endmodule

@@ test/tb_restriction_site_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_restriction_site_scanner
// Feeds reads to the restriction site scanner under several site settings,
// with random gaps and stalls on both channels, and reports the verdict of
// the result checker.
// ----------------------------------------------------------------------------
module tb_restriction_site_scanner;
    import rss_pkg::*;

    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 60;
    localparam int RANDOM_BASES  = 950;
    localparam int PHASES        = 8;
    localparam int OVERFLOW_READ = 1030;

    localparam t_base BASE_A   = 3'd0;
    localparam t_base BASE_C   = 3'd1;
    localparam t_base BASE_G   = 3'd2;
    localparam t_base BASE_T   = 3'd3;
    localparam t_base BASE_TOP = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    t_base                 i_base     = BASE_A;
    logic                  i_read_end = 1'b0;
    logic                  i_ready    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;

    logic                  o_ready;
    logic                  o_valid;
    logic                  o_kind;
    t_pos                  o_position;
    t_pos                  o_longest_start;
    t_pos                  o_longest_length;
    t_pos                  o_cut_count;
    logic                  o_overflow;
    logic                  o_last;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    records_due;

    // Stimulus state
    logic                  steady       = 1'b0;
    logic                  hold_results = 1'b0;
    int                    bases_sent   = 0;
    logic [PATTERN_W-1:0]  site_bits    = '0;
    int                    site_span    = 4;
    t_base                 read_bases [$];

    restriction_site_scanner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_base           (i_base),
        .i_read_end       (i_read_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_position       (o_position),
        .o_longest_start  (o_longest_start),
        .o_longest_length (o_longest_length),
        .o_cut_count      (o_cut_count),
        .o_overflow       (o_overflow),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    rss_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base_valid   (i_valid),
        .i_base_ready   (o_ready),
        .i_base         (i_base),
        .i_read_end     (i_read_end),
        .i_result_valid (o_valid),
        .i_result_ready (i_ready),
        .i_result       ({o_kind, o_position, o_longest_start, o_longest_length,
                          o_cut_count, o_overflow, o_last}),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fault_count  (mismatches),
        .o_records_due  (records_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Result receiver: random back-pressure, or a long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                i_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Offer one base and wait for the transaction
    task automatic offer_base(input t_base b, input logic last_base);
        if (!steady && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= b;
        i_read_end <= last_base;
        do @(posedge i_clk); while (!o_ready);
        bases_sent++;
    endtask

    task automatic send_read();
        for (int k = 0; k < read_bases.size(); k++) begin
            offer_base(read_bases[k], k == read_bases.size() - 1);
        end
    endtask

    // Build a read of roughly the given length: site copies, copies cut
    // short by one base, and random noise including non-matching codes
    task automatic make_read(input int length);
        int roll;
        int stop;
        read_bases.delete();
        while (read_bases.size() < length) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                stop = (roll < 35) ? site_span : site_span - 1;
                for (int k = 0; k < stop; k++) begin
                    read_bases = {read_bases, t_base'(site_bits[2*k +: 2])};
                end
            end else if ($urandom_range(0, 99) < 85) begin
                read_bases = {read_bases, t_base'($urandom_range(BASE_A, BASE_T))};
            end else begin
                read_bases = {read_bases, t_base'($urandom_range(BASE_NONE, BASE_TOP))};
            end
        end
    endtask

    // Hold input until every expected result is out and the pipe is empty
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (records_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_site(input logic [PATTERN_W-1:0] pattern, input int len,
                            input int off, input logic only_longest);
        drain_results();
        write_reg(REG_SITE_PATTERN, pattern);
        write_reg(REG_SITE_LENGTH, 32'(len));
        write_reg(REG_CUT_OFFSET, 32'(off));
        write_reg(REG_LONG_MODE, 32'(only_longest));
        site_bits = pattern;
        site_span = (len < 1) ? 1 : ((len > MAX_SITE_BASES) ? MAX_SITE_BASES : len);
    endtask

    initial begin
        int phase;
        int random_start;
        int length;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset site AAAA: overlapping copy is skipped
        read_bases = '{BASE_A, BASE_A, BASE_A, BASE_A, BASE_A};
        send_read();
        // Every base code but A, the non-matching ones included
        read_bases = '{BASE_C, BASE_G, BASE_T};
        for (int c = BASE_NONE; c <= BASE_TOP; c++) read_bases = {read_bases, t_base'(c)};
        send_read();
        // One-base read
        read_bases = '{BASE_A};
        send_read();
        // Zero length and zero offset both clamp to one
        set_site('1, 0, 0, 1'b0);
        read_bases = '{BASE_T, BASE_C, BASE_T, BASE_T};
        send_read();
        // Site AC cut inside; equal fragments keep the first
        set_site({BASE_C[1:0], BASE_A[1:0]}, 2, 2, 1'b0);
        read_bases = '{BASE_A, BASE_C, BASE_A, BASE_C};
        send_read();
        read_bases = '{BASE_C, BASE_A, BASE_C, BASE_G};
        send_read();

        // Random reads under a series of site settings
        random_start = bases_sent;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_site($urandom, 16, 16, 1'b0);
                1: set_site($urandom, 31, 0, 1'b1);
                2: set_site($urandom, 1, 1, 1'b0);
                3: set_site('0, 3, 20, 1'b0);
                4: set_site($urandom, 17, 31, 1'b0);
                default: set_site($urandom, $urandom_range(0, 31), $urandom_range(0, 31),
                                  1'($urandom_range(0, 1)));
            endcase
            steady = (phase == 2);
            if (phase == 4) hold_results = 1'b1;
            while (bases_sent - random_start < RANDOM_BASES * (phase + 1) / PHASES) begin
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150)
                                                     : $urandom_range(1, 40);
                make_read(length);
                send_read();
                if (phase == 5 && $urandom_range(0, 7) == 0) drain_results();
            end
        end
        steady = 1'b0;

        // One read past the maximum length, ending on a dropped base
        set_site($urandom, 3, 2, 1'b0);
        make_read(OVERFLOW_READ);
        send_read();

        drain_results();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
